>>> hw/rtl/lrss_pkg.sv
// Shared types and constants for the light rating slot selector.
// Used by the front, queue, back and top level; no dependencies.
package lrss_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int QDEPTH_DEF = 2;

    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_OFFER = 2'd1;
    localparam logic [1:0] KIND_EMIT  = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam logic [1:0] OUT_APPEND  = 2'd0;
    localparam logic [1:0] OUT_REPLACE = 2'd1;
    localparam logic [1:0] OUT_REJECT  = 2'd2;
    localparam logic [1:0] OUT_ENTRY   = 2'd3;

    localparam logic [31:0] RATE_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] id;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [32:0] az;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;
    } t_item;

endpackage

>>> hw/rtl/light_rating_slot_selector.sv
// Top level of the light rating slot selector: front, queue and back.
// Depends on lrss_pkg, lrss_front, lrss_queue and lrss_back.
//
// A command word is taken when start is high and busy is low; busy rises only
// when the two-word queue between front and back is full. Begin is handled at
// the back in its idle state, emit gives one result a cycle (count results, or
// one for an empty list). An offer that is appended goes through the back in
// order: taking the word, the squared distance on the shared multiplier, the
// digit square root, the attenuation terms and sum, and the append; with a full
// list a scan over the slots replaces an entry or rejects the offer instead.
// Results appear for one cycle with o_strobe high and cannot be held off by
// the receiver.
module light_rating_slot_selector import lrss_pkg::*; #(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int QDEPTH = QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_light_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0] i_coef_const,
    input  logic [31:0] i_coef_linear,
    input  logic [31:0] i_coef_quad,
    output logic        o_strobe,
    output logic [1:0]  o_outcome,
    output logic [2:0]  o_slot,
    output logic [15:0] o_out_id,
    output logic [31:0] o_out_rating,
    output logic        o_valid_res,
    output logic        o_last
);
    logic  push;
    logic  pop;
    logic  full;
    logic  nonempty;
    t_item fw;
    t_item bw;

    assign busy = full;

    lrss_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (start && !full),
        .i_kind        (i_kind),
        .i_light_id    (i_light_id),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_coef_const  (i_coef_const),
        .i_coef_linear (i_coef_linear),
        .i_coef_quad   (i_coef_quad),
        .o_push        (push),
        .o_word        (fw)
    );

    lrss_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_word     (fw),
        .i_pop      (pop),
        .o_word     (bw),
        .o_full     (full),
        .o_nonempty (nonempty)
    );

    lrss_back #(.SLOTS(SLOTS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_nonempty   (nonempty),
        .i_word       (bw),
        .o_pop        (pop),
        .o_strobe     (o_strobe),
        .o_outcome    (o_outcome),
        .o_slot       (o_slot),
        .o_out_id     (o_out_id),
        .o_out_rating (o_out_rating),
        .o_valid_res  (o_valid_res),
        .o_last       (o_last)
    );
endmodule

>>> hw/rtl/lrss_queue.sv
// Short FIFO of classified words between front and back.
// Depends on lrss_pkg for the word type.
module lrss_queue import lrss_pkg::*; #(
    parameter int DEPTH = QDEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_word,
    input  logic  i_pop,
    output t_item o_word,
    output logic  o_full,
    output logic  o_nonempty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    t_item          r_mem [DEPTH];
    logic [PW-1:0]  r_head;
    logic [PW-1:0]  r_tail;
    logic [FW-1:0]  r_fill;

    assign o_word     = r_mem[r_head];
    assign o_full     = (r_fill == FW'(DEPTH));
    assign o_nonempty = (r_fill != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_word;
        end
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == PW'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == PW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end
endmodule

>>> hw/rtl/lrss_front.sv
// Front end: accepts command words, holds the focus, forms distance magnitudes.
// Depends on lrss_pkg for kind codes and the word type.
module lrss_front import lrss_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_light_id,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0] i_coef_const,
    input  logic [31:0] i_coef_linear,
    input  logic [31:0] i_coef_quad,
    output logic        o_push,
    output t_item       o_word
);
    logic signed [31:0] r_fx;
    logic signed [31:0] r_fy;
    logic signed [31:0] r_fz;

    function automatic logic [32:0] absdiff(input logic signed [31:0] p,
                                            input logic signed [31:0] f);
        logic signed [32:0] d;
        d = 33'(p) - 33'(f);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    assign o_push = i_accept && (i_kind != KIND_NONE);

    always_comb begin
        o_word.kind = i_kind;
        o_word.id   = i_light_id;
        o_word.ax   = absdiff(i_pos_x, r_fx);
        o_word.ay   = absdiff(i_pos_y, r_fy);
        o_word.az   = absdiff(i_pos_z, r_fz);
        o_word.c0   = i_coef_const;
        o_word.c1   = i_coef_linear;
        o_word.c2   = i_coef_quad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx <= '0;
            r_fy <= '0;
            r_fz <= '0;
        end else if (i_accept && i_kind == KIND_BEGIN) begin
            r_fx <= i_pos_x;
            r_fy <= i_pos_y;
            r_fz <= i_pos_z;
        end
    end
endmodule

>>> hw/rtl/lrss_back.sv
// Back end: rating sequencer (shared multiplier, digit square root), slot list.
// Depends on lrss_pkg for codes and the word type.
module lrss_back import lrss_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nonempty,
    input  t_item       i_word,
    output logic        o_pop,
    output logic        o_strobe,
    output logic [1:0]  o_outcome,
    output logic [2:0]  o_slot,
    output logic [15:0] o_out_id,
    output logic [31:0] o_out_rating,
    output logic        o_valid_res,
    output logic        o_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ     = 4'd1;
    localparam logic [3:0] ST_SQRT   = 4'd2;
    localparam logic [3:0] ST_LIN    = 4'd3;
    localparam logic [3:0] ST_QLO    = 4'd4;
    localparam logic [3:0] ST_QHI    = 4'd5;
    localparam logic [3:0] ST_SUM    = 4'd6;
    localparam logic [3:0] ST_DECIDE = 4'd7;
    localparam logic [3:0] ST_SCAN   = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    logic [3:0]    r_state;
    logic [5:0]    r_cnt;
    t_item         r_it;
    logic [65:0]   r_acc;
    logic [67:0]   r_sv;
    logic [36:0]   r_rem;
    logic [33:0]   r_root;
    logic [67:0]   r_prod;
    logic [31:0]   r_lin;
    logic [31:0]   r_plo;
    logic [31:0]   r_rate;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;
    logic [15:0]   r_light  [SLOTS];
    logic [31:0]   r_rating [SLOTS];

    logic [33:0] m_a;
    logic [33:0] m_b;
    logic [67:0] m_p;
    logic [36:0] rem_sh;
    logic [36:0] trial;
    logic        ge;
    logic [64:0] qsum;
    logic [31:0] quad;
    logic [33:0] tot;
    logic [31:0] rating;
    logic        n_strobe;

    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_state)
            ST_SQ: begin
                if (r_cnt == 6'd0) begin
                    m_a = 34'(r_it.ax);
                end else if (r_cnt == 6'd1) begin
                    m_a = 34'(r_it.ay);
                end else begin
                    m_a = 34'(r_it.az);
                end
                m_b = m_a;
            end
            ST_LIN: begin
                m_a = 34'(r_it.c1);
                m_b = r_root;
            end
            ST_QLO: begin
                m_a = 34'(r_it.c2);
                m_b = 34'(r_acc[31:0]);
            end
            ST_QHI: begin
                m_a = 34'(r_it.c2);
                m_b = 34'(r_acc[63:32]);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = m_a * m_b;
    end

    assign rem_sh = {r_rem[34:0], r_sv[67:66]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_comb begin
        qsum = {1'b0, r_prod[63:0]} + 65'(r_plo);
        if (qsum[64:32] != '0 || (r_acc[65:64] != 2'b00 && r_it.c2 != '0)) begin
            quad = RATE_MAX;
        end else begin
            quad = qsum[31:0];
        end
        tot    = 34'(r_it.c0) + 34'(r_lin) + 34'(quad);
        rating = (tot[33:32] != 2'b00) ? RATE_MAX : tot[31:0];
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: n_strobe = i_nonempty && (i_word.kind == KIND_EMIT) && (r_count == '0);
            ST_DECIDE: n_strobe = (r_count < CW'(SLOTS));
            ST_SCAN: n_strobe = (r_rate < r_rating[r_idx]) || (r_idx == IW'(SLOTS - 1));
            ST_EMIT: n_strobe = 1'b1;
            default: n_strobe = 1'b0;
        endcase
    end

    assign o_pop = (r_state == ST_IDLE) && i_nonempty;

    always_ff @(posedge i_clk) begin
        r_prod <= m_p;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_cnt    <= '0;
            r_idx    <= '0;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= n_strobe;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_nonempty) begin
                        r_it  <= i_word;
                        r_cnt <= '0;
                        r_idx <= '0;
                        unique case (i_word.kind)
                            KIND_BEGIN: r_count <= '0;
                            KIND_OFFER: begin
                                r_acc   <= '0;
                                r_state <= ST_SQ;
                            end
                            KIND_EMIT: begin
                                if (r_count == '0) begin
                                    o_outcome    <= OUT_ENTRY;
                                    o_slot       <= '0;
                                    o_out_id     <= '0;
                                    o_out_rating <= '0;
                                    o_valid_res  <= 1'b0;
                                    o_last       <= 1'b1;
                                end else begin
                                    r_state <= ST_EMIT;
                                end
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end
                end
                ST_SQ: begin
                    if (r_cnt != 6'd0) begin
                        r_acc <= r_acc + 66'(r_prod);
                    end
                    if (r_cnt == 6'd3) begin
                        r_sv    <= {2'b00, r_acc + 66'(r_prod)};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SQRT: begin
                    r_rem  <= ge ? rem_sh - trial : rem_sh;
                    r_root <= {r_root[32:0], ge};
                    r_sv   <= {r_sv[65:0], 2'b00};
                    if (r_cnt == 6'd33) begin
                        r_state <= ST_LIN;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_LIN: r_state <= ST_QLO;
                ST_QLO: begin
                    r_lin   <= (r_prod[65:48] != '0) ? RATE_MAX : r_prod[47:16];
                    r_state <= ST_QHI;
                end
                ST_QHI: begin
                    r_plo   <= r_prod[63:32];
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rate  <= rating;
                    r_state <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (r_count < CW'(SLOTS)) begin
                        r_light[r_count[IW-1:0]]  <= r_it.id;
                        r_rating[r_count[IW-1:0]] <= r_rate;
                        r_count      <= r_count + 1'b1;
                        o_outcome    <= OUT_APPEND;
                        o_slot       <= 3'(r_count[IW-1:0]);
                        o_out_id     <= r_it.id;
                        o_out_rating <= r_rate;
                        o_valid_res  <= 1'b1;
                        o_last       <= 1'b0;
                        r_state      <= ST_IDLE;
                    end else begin
                        r_idx   <= '0;
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (r_rate < r_rating[r_idx]) begin
                        r_light[r_idx]  <= r_it.id;
                        r_rating[r_idx] <= r_rate;
                        o_outcome    <= OUT_REPLACE;
                        o_slot       <= 3'(r_idx);
                        o_out_id     <= r_it.id;
                        o_out_rating <= r_rate;
                        o_valid_res  <= 1'b1;
                        o_last       <= 1'b0;
                        r_state      <= ST_IDLE;
                    end else if (r_idx == IW'(SLOTS - 1)) begin
                        o_outcome    <= OUT_REJECT;
                        o_slot       <= '0;
                        o_out_id     <= r_it.id;
                        o_out_rating <= r_rate;
                        o_valid_res  <= 1'b1;
                        o_last       <= 1'b0;
                        r_state      <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_EMIT: begin
                    o_outcome    <= OUT_ENTRY;
                    o_slot       <= 3'(r_idx);
                    o_out_id     <= r_light[r_idx];
                    o_out_rating <= r_rating[r_idx];
                    o_valid_res  <= 1'b1;
                    if (CW'(r_idx) + 1'b1 == r_count) begin
                        o_last  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        o_last <= 1'b0;
                        r_idx  <= r_idx + 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
